### hw/rtl/rtpc_pkg.sv
package rtpc_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAC_HDR_LEN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEER_EN    = 1'd1;

  localparam logic [6:0]  MAC_HDR_LEN_RST = 7'd14;
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [1:0]  RTP_VERSION     = 2'b10;
  localparam logic [7:0]  RTCP_SR_TYPE    = 8'd200;
  localparam logic [15:0] MIN_PORT        = 16'd1024;
  localparam logic [15:0] PORT_EVEN_MASK  = 16'hfffe;
  localparam logic [8:0]  MIN_UDP_TAIL    = 9'd20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        keep;
    logic        hash_valid;
    logic [31:0] flow_hash;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  byte_pos;
    logic [7:0]  udp_offset;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  rtp_byte0;
    logic [7:0]  rtp_byte1;
  } frame_t;

  function automatic logic codec_allowed(input logic [7:0] pt);
    logic ok;
    ok = (pt < 8'd19) || (pt > 8'd95);
    case (pt) inside
      8'd25, 8'd26, 8'd28, [8'd31:8'd34]: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

### hw/rtl/rtpc_check.sv
module rtpc_check import rtpc_pkg::*; (
  input  frame_t    frame,
  input  logic      steer_en,
  output out_word_t result
);

  logic [8:0] frame_len;
  logic [8:0] min_len;
  logic       sport_odd;
  logic       dport_odd;
  logic       keep;

  always_comb begin
    frame_len = {1'b0, frame.byte_pos} + 9'd1;
    min_len   = {1'b0, frame.udp_offset} + MIN_UDP_TAIL;
    sport_odd = frame.src_port[0];
    dport_odd = frame.dst_port[0];
    keep = 1'b1;
    if (frame.ether_type != ETHERTYPE_IPV4) keep = 1'b0;
    if (frame_len < min_len) keep = 1'b0;
    if (frame.ip_protocol != PROTO_UDP) keep = 1'b0;
    if (frame.rtp_byte0[7:6] != RTP_VERSION) keep = 1'b0;
    if (frame.src_port < MIN_PORT || frame.dst_port < MIN_PORT) keep = 1'b0;
    if (sport_odd && dport_odd) begin
      if (frame.rtp_byte1 != RTCP_SR_TYPE) keep = 1'b0;
    end else if (!sport_odd && !dport_odd) begin
      if (!codec_allowed(frame.rtp_byte1)) keep = 1'b0;
    end
    result.keep       = keep;
    result.hash_valid = keep && steer_en;
    if (keep && steer_en) begin
      result.flow_hash = frame.src_addr ^ frame.dst_addr ^
                         {frame.src_port & PORT_EVEN_MASK, frame.dst_port & PORT_EVEN_MASK};
    end else begin
      result.flow_hash = 32'd0;
    end
  end

endmodule

### hw/rtl/rtp_packet_classifier.sv
// rtp/rtcp classifier for ethernet frames carrying ipv4 and udp
//
// input channel: one frame byte per word (in_valid / in_stall / in_data),
// last_byte marks the final byte; a new byte can be taken every cycle unless in_stall is high
// output channel: one result word per frame (out_valid / out_stall / out_data)
// carrying keep, hash_valid and flow_hash
// result: registered, shown in the cycle after the last byte is taken
// throughput: one byte per cycle while in_stall is low, set by the single capture stage feeding
// the result register
// stall: a held result only blocks a last byte; other bytes keep flowing
// config: cfg_we writes mac_header_length (index 0) or steer_enable (index 1);
// the user must write only while no frame is in flight; the block does not enforce it
// reset: rst_n (synchronous, active low) clears the capture state and out_valid,
// and sets mac_header_length to 14, steer_enable to 0
module rtp_packet_classifier import rtpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [6:0]  mac_len_r;
  logic        steer_en_r;

  logic [7:0]  pos_r;
  logic [15:0] ether_type_r;
  logic [3:0]  ihl_r;
  logic [7:0]  proto_r;
  logic [31:0] saddr_r;
  logic [31:0] daddr_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [7:0]  rtp0_r;
  logic [7:0]  rtp1_r;

  logic [7:0]  pos_nxt;
  logic [15:0] ether_type_nxt;
  logic [3:0]  ihl_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] saddr_nxt;
  logic [31:0] daddr_nxt;
  logic [15:0] sport_nxt;
  logic [15:0] dport_nxt;
  logic [7:0]  rtp0_nxt;
  logic [7:0]  rtp1_nxt;

  logic        out_valid_r;
  out_word_t   out_data_r;

  logic [8:0]  pos9;
  logic [8:0]  m9;
  logic [8:0]  u9;
  logic [7:0]  b;
  logic        in_accept;
  frame_t      frame;
  out_word_t   result;

  assign in_stall  = out_valid_r && out_stall && in_data.last_byte;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // field capture for the current byte
  always_comb begin
    b    = in_data.data_byte;
    pos9 = {1'b0, pos_r};
    m9   = {2'b00, mac_len_r};
    ether_type_nxt = ether_type_r;
    proto_nxt      = proto_r;
    saddr_nxt      = saddr_r;
    daddr_nxt      = daddr_r;
    sport_nxt      = sport_r;
    dport_nxt      = dport_r;
    rtp0_nxt       = rtp0_r;
    rtp1_nxt       = rtp1_r;
    if (pos9 == 9'd12) ether_type_nxt[15:8] = b;
    if (pos9 == 9'd13) ether_type_nxt[7:0] = b;
    ihl_nxt = (pos9 == m9) ? b[3:0] : ihl_r;
    if (pos9 == m9 + 9'd9) proto_nxt = b;
    if (pos9 >= m9 + 9'd12 && pos9 <= m9 + 9'd15) saddr_nxt = {saddr_r[23:0], b};
    if (pos9 >= m9 + 9'd16 && pos9 <= m9 + 9'd19) daddr_nxt = {daddr_r[23:0], b};
    u9 = m9 + {3'b000, ihl_nxt, 2'b00};
    if (pos9 == u9) sport_nxt[15:8] = b;
    if (pos9 == u9 + 9'd1) sport_nxt[7:0] = b;
    if (pos9 == u9 + 9'd2) dport_nxt[15:8] = b;
    if (pos9 == u9 + 9'd3) dport_nxt[7:0] = b;
    if (pos9 == u9 + 9'd8) rtp0_nxt = b;
    if (pos9 == u9 + 9'd9) rtp1_nxt = b;
    pos_nxt = (pos_r == 8'hff) ? pos_r : pos_r + 8'd1;

    frame.byte_pos    = pos_r;
    frame.udp_offset  = u9[7:0];
    frame.ether_type  = ether_type_nxt;
    frame.ip_protocol = proto_nxt;
    frame.src_addr    = saddr_nxt;
    frame.dst_addr    = daddr_nxt;
    frame.src_port    = sport_nxt;
    frame.dst_port    = dport_nxt;
    frame.rtp_byte0   = rtp0_nxt;
    frame.rtp_byte1   = rtp1_nxt;
  end

  rtpc_check u_check (
    .frame    (frame),
    .steer_en (steer_en_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_len_r  <= MAC_HDR_LEN_RST;
      steer_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAC_HDR_LEN: mac_len_r  <= cfg_wdata;
        CFG_STEER_EN:    steer_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_data.last_byte)) begin
      pos_r        <= '0;
      ether_type_r <= '0;
      ihl_r        <= '0;
      proto_r      <= '0;
      saddr_r      <= '0;
      daddr_r      <= '0;
      sport_r      <= '0;
      dport_r      <= '0;
      rtp0_r       <= '0;
      rtp1_r       <= '0;
    end else if (in_accept) begin
      pos_r        <= pos_nxt;
      ether_type_r <= ether_type_nxt;
      ihl_r        <= ihl_nxt;
      proto_r      <= proto_nxt;
      saddr_r      <= saddr_nxt;
      daddr_r      <= daddr_nxt;
      sport_r      <= sport_nxt;
      dport_r      <= dport_nxt;
      rtp0_r       <= rtp0_nxt;
      rtp1_r       <= rtp1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_byte) begin
      out_data_r <= result;
    end
  end

  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_byte |=> out_valid_r)
    else $error("last byte accepted without a result word");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_byte |=> pos_r == 8'd0)
    else $error("byte position not cleared after last byte");

  a_hash_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.hash_valid |-> out_data_r.flow_hash == 32'd0)
    else $error("flow hash nonzero without hash_valid");

  a_hash_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_byte && !steer_en_r |=> !out_data_r.hash_valid)
    else $error("hash reported with steering off");

endmodule
